// ----- hdl/resl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resl_pkg
// shared types and constants for the relational event stats block
// ----------------------------------------------------------------------------
package resl_pkg;

    localparam int STAT_COUNT = 11;
    localparam int LANE_W     = 16;

    typedef enum logic {
        OP_OBSERVE = 1'b0,
        OP_LOAD    = 1'b1
    } op_t;

    typedef struct packed {
        logic               operation;
        logic [3:0]         sender;
        logic [3:0]         receiver;
        logic [1:0]         sender_class;
        logic [1:0]         receiver_class;
        logic [7:0]         coef_index;
        logic signed [31:0] coef_value;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] log_rate;
        logic               rejected;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_STATS,
        ST_WAIT_STATS,
        ST_RD_COEF,
        ST_ACC,
        ST_MUL,
        ST_SUM,
        ST_SCAN_RD,
        ST_SCAN_WR,
        ST_OUT
    } state_t;

endpackage

// ----- hdl/resl_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resl_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module resl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- hdl/resl_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resl_update
// next stats word of one dyad for an event
// ----------------------------------------------------------------------------
module resl_update #(
    parameter int AW = 4,
    parameter int CW = 16
) (
    input  logic [AW-1:0]     a,
    input  logic [AW-1:0]     b,
    input  logic [AW-1:0]     i,
    input  logic [AW-1:0]     j,
    input  logic [6+4*CW-1:0] old_word,
    output logic              touched,
    output logic [6+4*CW-1:0] new_word
);
    import resl_pkg::*;

    logic ia, ib, ja, jb;
    logic [5:0] f;
    logic [3:0] hit;
    logic [CW-1:0] lane;

    always_comb
    begin
        ia = (i == a);
        ib = (i == b);
        ja = (j == a);
        jb = (j == b);
        touched = (i != j) && (ia || ib || ja || jb);
        f[0] = !ia && ib && ja && !jb;
        f[1] = !ia && ib && !ja && !jb;
        f[2] = !ia && !ib && ja && !jb;
        f[3] = !ia && !ib && !ja && jb;
        f[4] = ia && !ib && !ja && !jb;
        f[5] = ia && !ib && !ja && jb;
        hit = {jb, ib, ja, ia};
        new_word = old_word;
        new_word[5:0] = f;
        for (int k = 0; k < 4; k++)
        begin
            lane = old_word[6+k*CW +: CW];
            if (hit[k] && lane != {CW{1'b1}})
            begin
                new_word[6+k*CW +: CW] = lane + CW'(1);
            end
        end
    end
endmodule

// ----- hdl/relational_event_stats_and_log_rate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relational_event_stats_and_log_rate
// per-dyad stats table with log-rate readout and event update
// ----------------------------------------------------------------------------
// One request at a time. The stats memory holds D = 2**(2*clog2(ACTORS)) dyad
// entries, ACTORS*ACTORS when ACTORS is a power of two. After reset a clearing
// pass writes every entry while in_ready is low. A load, or an observe with an
// actor out of range, goes straight to the result. An observe does 11
// coefficient reads and 4 multiply-accumulates, then a read per dyad and a
// write-back of each touched dyad on the single port of the stats memory. A
// self event skips the write-back scan. The result is held while out_ready
// is low.
module relational_event_stats_and_log_rate #(
    parameter int ACTORS      = 16,
    parameter int CLASSES     = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  resl_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output resl_pkg::out_item_t out_data
);
    import resl_pkg::*;

    localparam int AW    = (ACTORS > 1) ? $clog2(ACTORS) : 1;
    localparam int DAW   = 2 * AW;
    localparam int DYADS = 1 << DAW;
    localparam int COEFS = STAT_COUNT * CLASSES * CLASSES;
    localparam int CAW   = $clog2(COEFS);
    localparam int SW    = 6 + 4 * COUNT_WIDTH;
    localparam logic signed [63:0] OMAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] OMIN = -64'sh0000_8000_0000_0000;

    state_t state_reg, state_next;
    logic [DAW:0] cnt_reg, cnt_next;
    logic [3:0] p_reg, p_next;
    logic [3:0] a_reg, a_next, b_reg, b_next;
    logic [CAW+2:0] base_reg, base_next;
    logic [SW-1:0] stat_reg, stat_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] prod_reg, prod_next;
    logic rej_reg, rej_next, coef_ok_reg, coef_ok_next;
    out_item_t out_reg, out_next;

    logic s_we;
    logic [DAW-1:0] s_addr;
    logic [SW-1:0] s_wdata, s_rdata;
    logic c_we;
    logic [CAW-1:0] c_addr;
    logic [31:0] c_wdata, c_rdata;

    logic touched;
    logic [SW-1:0] upd_word;
    logic [CAW+2:0] slot;
    logic signed [32:0] cval;
    logic [COUNT_WIDTH-1:0] lane_v;
    logic signed [COUNT_WIDTH+33:0] mul_v;

    resl_ram #(.WIDTH(SW), .DEPTH(DYADS)) u_stats (
        .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
    );

    resl_ram #(.WIDTH(32), .DEPTH(COEFS)) u_coef (
        .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata)
    );

    resl_update #(.AW(AW), .CW(COUNT_WIDTH)) u_upd (
        .a(AW'(a_reg)), .b(AW'(b_reg)),
        .i(cnt_reg[DAW-1:AW]), .j(cnt_reg[AW-1:0]),
        .old_word(s_rdata), .touched(touched), .new_word(upd_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg       <= p_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        base_reg    <= base_next;
        stat_reg    <= stat_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        rej_reg     <= rej_next;
        coef_ok_reg <= coef_ok_next;
        out_reg     <= out_next;
    end

    assign out_data = out_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        p_next       = p_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        base_next    = base_reg;
        stat_next    = stat_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        rej_next     = rej_reg;
        coef_ok_next = coef_ok_reg;
        out_next     = out_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        s_we         = 1'b0;
        s_addr       = cnt_reg[DAW-1:0];
        s_wdata      = '0;
        c_we         = 1'b0;
        c_wdata      = in_data.coef_value;
        c_addr       = '0;
        slot         = base_reg + (CAW+3)'(p_reg);
        cval         = coef_ok_reg ? 33'(signed'(c_rdata)) : '0;
        lane_v       = '0;
        mul_v        = '0;
        if (slot < (CAW+3)'(COEFS))
        begin
            c_addr = slot[CAW-1:0];
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                s_we = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (DAW+1)'(DYADS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    a_next = in_data.sender;
                    b_next = in_data.receiver;
                    base_next = (CAW+3)'(STAT_COUNT * (32'(in_data.sender_class)
                        + CLASSES * 32'(in_data.receiver_class)));
                    acc_next = '0;
                    p_next = '0;
                    if (in_data.operation == OP_LOAD)
                    begin
                        c_addr = CAW'(in_data.coef_index);
                        c_we = (32'(in_data.coef_index) < COEFS);
                        out_next = '0;
                        state_next = ST_OUT;
                    end
                    else if (32'(in_data.sender) >= ACTORS
                        || 32'(in_data.receiver) >= ACTORS)
                    begin
                        out_next = '{log_rate: '0, rejected: 1'b1};
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        rej_next = (in_data.sender == in_data.receiver);
                        state_next = ST_RD_STATS;
                    end
                end
            end
            ST_RD_STATS:
            begin
                s_addr = {AW'(a_reg), AW'(b_reg)};
                state_next = ST_WAIT_STATS;
            end
            ST_WAIT_STATS:
            begin
                stat_next = s_rdata;
                state_next = ST_RD_COEF;
            end
            ST_RD_COEF:
            begin
                coef_ok_next = (slot < (CAW+3)'(COEFS));
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (p_reg <= 4'd6)
                begin
                    if (p_reg == 4'd0 || stat_reg[p_reg - 4'd1])
                    begin
                        acc_next = acc_reg + 64'(cval);
                    end
                    p_next = p_reg + 4'd1;
                    state_next = ST_RD_COEF;
                end
                else
                begin
                    lane_v = stat_reg[6 + (32'(p_reg) - 7) * COUNT_WIDTH +: COUNT_WIDTH];
                    mul_v = signed'({1'b0, lane_v}) * cval;
                    prod_next = 64'(mul_v);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                acc_next = acc_reg + prod_reg;
                if (p_reg == 4'd10)
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    p_next = p_reg + 4'd1;
                    state_next = ST_RD_COEF;
                end
            end
            ST_SUM:
            begin
                out_next.rejected = rej_reg;
                if (acc_reg > OMAX)
                begin
                    out_next.log_rate = OMAX[47:0];
                end
                else if (acc_reg < OMIN)
                begin
                    out_next.log_rate = OMIN[47:0];
                end
                else
                begin
                    out_next.log_rate = acc_reg[47:0];
                end
                cnt_next = '0;
                state_next = rej_reg ? ST_OUT : ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_WR;
            end
            ST_SCAN_WR:
            begin
                s_we = touched;
                s_wdata = upd_word;
                cnt_next = cnt_reg + 1'b1;
                state_next = (cnt_reg == (DAW+1)'(DYADS - 1)) ? ST_OUT : ST_SCAN_RD;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ----- sim/tb_relational_event_stats_and_log_rate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_relational_event_stats_and_log_rate
// self-checking bench for the relational event stats and log-rate block
// ----------------------------------------------------------------------------
// The coefficient table is filled first, then a short directed list covers the
// boundary actors, the class extremes, self events, extreme coefficient values
// and loads to slots outside the table. A random mix of observe and load
// requests follows. A scoreboard keeps its own copy of the dyad stats and the
// coefficient table, predicts every result and checks it in order while both
// handshakes are idled at random.
// ----------------------------------------------------------------------------
module tb_relational_event_stats_and_log_rate;

    import resl_pkg::*;

    localparam int N_ACTORS   = 16;
    localparam int N_CLASSES  = 4;
    localparam int N_COEFS    = STAT_COUNT * N_CLASSES * N_CLASSES;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_WAIT = 2 * N_ACTORS * N_ACTORS + 60;

    class stats_scoreboard;
        bit [5:0]           flags [N_ACTORS*N_ACTORS];
        bit [15:0]          degree [N_ACTORS*N_ACTORS][4];
        logic signed [31:0] coef [N_COEFS];
        out_item_t          pending [$];
        int                 mismatches;

        function longint coef_at(int slot);
            if (slot >= N_COEFS)
                return 0;
            return longint'(coef[slot]);
        endfunction

        function void note_request(in_item_t r);
            out_item_t exp_res;
            longint    acc;
            int        base, d;
            bit        ia, ib, ja, jb;
            bit [5:0]  f;
            exp_res = '0;
            if (r.operation == OP_LOAD) begin
                if (r.coef_index < N_COEFS)
                    coef[r.coef_index] = r.coef_value;
            end
            else begin
                base = STAT_COUNT * (r.sender_class + N_CLASSES * r.receiver_class);
                d = r.sender * N_ACTORS + r.receiver;
                acc = coef_at(base);
                for (int p = 1; p <= 6; p++)
                    if (flags[d][p-1])
                        acc += coef_at(base + p);
                for (int p = 0; p < 4; p++)
                    acc += longint'(degree[d][p]) * coef_at(base + 7 + p);
                if (acc > 64'sh7FFF_FFFF_FFFF)
                    acc = 64'sh7FFF_FFFF_FFFF;
                if (acc < -64'sh8000_0000_0000)
                    acc = -64'sh8000_0000_0000;
                exp_res.log_rate = acc[47:0];
                if (r.sender == r.receiver)
                    exp_res.rejected = 1'b1;
                else begin
                    for (int i = 0; i < N_ACTORS; i++) begin
                        for (int j = 0; j < N_ACTORS; j++) begin
                            ia = (i == r.sender);
                            ib = (i == r.receiver);
                            ja = (j == r.sender);
                            jb = (j == r.receiver);
                            if (i != j && (ia || ib || ja || jb)) begin
                                f = '0;
                                f[0] = !ia && ib && ja && !jb;
                                f[1] = !ia && ib && !ja && !jb;
                                f[2] = !ia && !ib && ja && !jb;
                                f[3] = !ia && !ib && !ja && jb;
                                f[4] = ia && !ib && !ja && !jb;
                                f[5] = ia && !ib && !ja && jb;
                                flags[i*N_ACTORS+j] = f;
                                bump(i*N_ACTORS+j, 0, ia);
                                bump(i*N_ACTORS+j, 1, ja);
                                bump(i*N_ACTORS+j, 2, ib);
                                bump(i*N_ACTORS+j, 3, jb);
                            end
                        end
                    end
                end
            end
            pending = {pending, exp_res};
        endfunction

        function void bump(int d, int lane, bit hit);
            if (hit && degree[d][lane] != 16'hFFFF)
                degree[d][lane]++;
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: log_rate %0d rejected %0b",
                             got.log_rate, got.rejected);
                return;
            end
            want = pending.pop_front();
            if (got.log_rate !== want.log_rate || got.rejected !== want.rejected) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: log_rate exp %0d got %0d, rejected exp %0b got %0b",
                             want.log_rate, got.log_rate, want.rejected, got.rejected);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    stats_scoreboard sb;
    int idle_cycles;
    int stall_left;
    bit no_stall;

    relational_event_stats_and_log_rate DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function int pick_gap();
        if (no_stall)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 2);
        return $urandom_range(5, 40);
    endfunction

    // result side: random stalls, with stall-free stretches
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_result(out_data);
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_request(in_item_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0 && in_valid) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        else if (gap > 0)
            repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(r);
    endtask

    function in_item_t load_req(int slot, logic [31:0] value);
        in_item_t r;
        r = in_item_t'(($bits(in_item_t))'({$urandom, $urandom}));
        r.operation  = OP_LOAD;
        r.coef_index = slot[7:0];
        r.coef_value = value;
        return r;
    endfunction

    function in_item_t observe_req(int a, int b, int ca, int cb);
        in_item_t r;
        r = in_item_t'(($bits(in_item_t))'({$urandom, $urandom}));
        r.operation      = OP_OBSERVE;
        r.sender         = a[3:0];
        r.receiver       = b[3:0];
        r.sender_class   = ca[1:0];
        r.receiver_class = cb[1:0];
        return r;
    endfunction

    function logic [31:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3, 4: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int a;
        sb = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        idle_cycles = 0;
        stall_left  = 0;
        no_stall    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // fill the coefficient table
        for (int s = 0; s < N_COEFS; s++)
            send_request(load_req(s, rand_coef()));

        // directed
        send_request(load_req(0, 32'h7FFF_FFFF));
        send_request(load_req(N_COEFS - 1, 32'h8000_0000));
        send_request(load_req(N_COEFS, 32'h1234_5678));
        send_request(load_req(255, 32'hFFFF_FFFF));
        send_request(observe_req(0, 15, 0, 0));
        send_request(observe_req(15, 0, 3, 3));
        send_request(observe_req(0, 15, 0, 0));
        send_request(observe_req(15, 15, 3, 0));
        send_request(observe_req(0, 0, 0, 3));
        send_request(observe_req(3, 7, 1, 2));
        send_request(observe_req(7, 3, 2, 1));
        send_request(observe_req(3, 9, 3, 3));
        send_request(observe_req(9, 7, 0, 0));
        send_request(observe_req(15, 0, 3, 3));
        send_request(load_req(N_COEFS - 1, 32'h7FFF_FFFF));
        send_request(observe_req(15, 0, 3, 3));

        // drain before the random part
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);

        // random
        for (int n = 0; n < 800; n++) begin
            if (n % 150 == 0)
                no_stall = ($urandom_range(0, 2) == 0);
            if (n == 400) begin
                in_valid <= 1'b0;
                while (sb.pending.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 9) < 4) begin
                if ($urandom_range(0, 9) == 0)
                    send_request(load_req($urandom_range(0, 255), rand_coef()));
                else
                    send_request(load_req($urandom_range(0, N_COEFS - 1), rand_coef()));
            end
            else begin
                a = $urandom_range(0, N_ACTORS - 1);
                if ($urandom_range(0, 15) == 0)
                    send_request(observe_req(a, a, $urandom_range(0, 3),
                                             $urandom_range(0, 3)));
                else
                    send_request(observe_req(a, (a + $urandom_range(1, N_ACTORS - 1))
                                             % N_ACTORS, $urandom_range(0, 3),
                                             $urandom_range(0, 3)));
            end
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
